@@ rtl/rrc_pkg.sv @@
// Shared types, widths and helpers for the rational reduce/compare block.
// Used by rrc_div, rrc_reduce and rational_reduce_compare; no dependencies.
`default_nettype none
package rrc_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int CNT_W      = $clog2(DATA_WIDTH + 1);
  localparam int IN_BITS    = ((4 * DATA_WIDTH + 7) / 8) * 8;
  localparam int OUT_FIELDS = 2 + 4 * DATA_WIDTH;
  localparam int OUT_BITS   = ((OUT_FIELDS + 7) / 8) * 8;

  typedef logic [DATA_WIDTH-1:0] word_t;

  typedef enum logic [2:0] {
    R_IDLE,
    R_CHECK,
    R_GCD,
    R_QN,
    R_QD
  } red_state_t;

  typedef enum logic [1:0] {
    T_IDLE,
    T_RUN1,
    T_RUN2,
    T_OUT
  } top_state_t;

  // Magnitude of a two's complement word; the most negative value maps to 2^(W-1).
  function automatic word_t abs_mag(word_t x);
    word_t r;
    r = x[DATA_WIDTH-1] ? word_t'(~x + word_t'(1)) : x;
    return r;
  endfunction

  // Sign and magnitude back to two's complement, wrapping at the word width.
  function automatic word_t from_sm(logic neg, word_t mag);
    word_t r;
    r = neg ? word_t'(~mag + word_t'(1)) : mag;
    return r;
  endfunction

endpackage
`default_nettype wire

@@ rtl/rational_reduce_compare.sv @@
// Rational reduce and compare: top level with stream handshakes and output register.
// Depends on rrc_pkg and rrc_reduce (which holds the shared rrc_div).
//
// Usage:
//   One input transaction on s_* carries two signed fractions. Each fraction is
//   reduced by the divisor that Euclid's truncating remainder loop finds (its
//   sign follows C remainder rules), and one output transaction on m_* carries
//   both reduced fractions, an equal flag and an invalid flag (0/0 present).
//   A 0/0 fraction reports 0/0 and forces the equal flag low.
// Timing:
//   Both fractions go through one reduce sequencer, one after the other, and
//   every Euclid step and final division uses the same one-bit-per-cycle
//   divider. s_tready is high only while idle.
// Reset: rst (synchronous, active high) returns to idle, holds s_tready low and drops m_tvalid.
// Stall: a finished result waits in the output register; the block still takes
//   the next input while it waits, and holds its next result until m_tready.
`default_nettype none
module rational_reduce_compare (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         s_tvalid,
  output logic                              s_tready,
  // first_numerator, first_denominator, second_numerator, second_denominator
  input  wire logic [rrc_pkg::IN_BITS-1:0]  s_tdata,
  output logic                              m_tvalid,
  input  wire logic                         m_tready,
  // fractions_equal, invalid_input, first_reduced_num, first_reduced_den,
  // second_reduced_num, second_reduced_den, zero pad
  output logic [rrc_pkg::OUT_BITS-1:0]      m_tdata
);

  localparam int W = rrc_pkg::DATA_WIDTH;

  rrc_pkg::top_state_t state, state_next;

  rrc_pkg::word_t n2, d2;
  rrc_pkg::word_t r1_num, r1_den, r2_num, r2_den;
  logic           r1_ok, r2_ok;

  logic           red_start;
  rrc_pkg::word_t red_num, red_den;
  logic           red_done, red_ok;
  rrc_pkg::word_t red_num_out, red_den_out;

  logic           s_take, m_load;
  logic           valid, equal;

  rrc_reduce u_reduce (
    .clk     (clk),
    .rst     (rst),
    .start   (red_start),
    .num     (red_num),
    .den     (red_den),
    .done    (red_done),
    .ok      (red_ok),
    .num_out (red_num_out),
    .den_out (red_den_out)
  );

  assign s_tready = (state == rrc_pkg::T_IDLE) && !rst;
  assign s_take   = s_tvalid && s_tready;
  assign valid    = r1_ok && r2_ok;
  assign equal    = valid && (r1_num == r2_num) && (r1_den == r2_den);

  // Next state; first fraction starts straight from the input bus.
  always_comb begin
    state_next = state;
    red_start  = 1'b0;
    red_num    = n2;
    red_den    = d2;
    m_load     = 1'b0;
    case (state)
      rrc_pkg::T_IDLE: begin
        red_num = s_tdata[W-1:0];
        red_den = s_tdata[2*W-1:W];
        if (s_take) begin
          red_start  = 1'b1;
          state_next = rrc_pkg::T_RUN1;
        end
      end
      rrc_pkg::T_RUN1: begin
        if (red_done) begin
          red_start  = 1'b1;
          state_next = rrc_pkg::T_RUN2;
        end
      end
      rrc_pkg::T_RUN2: begin
        if (red_done) state_next = rrc_pkg::T_OUT;
      end
      rrc_pkg::T_OUT: begin
        // hold until the output register is free
        if (!m_tvalid || m_tready) begin
          m_load     = 1'b1;
          state_next = rrc_pkg::T_IDLE;
        end
      end
      default: state_next = rrc_pkg::T_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= rrc_pkg::T_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (m_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Payload: second fraction operands, per-fraction results, output register.
  always_ff @(posedge clk) begin
    if (s_take) begin
      n2 <= s_tdata[3*W-1:2*W];
      d2 <= s_tdata[4*W-1:3*W];
    end
    if (state == rrc_pkg::T_RUN1 && red_done) begin
      r1_ok  <= red_ok;
      r1_num <= red_num_out;
      r1_den <= red_den_out;
    end
    if (state == rrc_pkg::T_RUN2 && red_done) begin
      r2_ok  <= red_ok;
      r2_num <= red_num_out;
      r2_den <= red_den_out;
    end
    if (m_load) begin
      m_tdata <= rrc_pkg::OUT_BITS'({r2_den, r2_num, r1_den, r1_num, !valid, equal});
    end
  end

endmodule
`default_nettype wire

@@ rtl/rrc_div.sv @@
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on rrc_pkg. Divisor must be nonzero.
`default_nettype none
module rrc_div (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire rrc_pkg::word_t dividend,
  input  wire rrc_pkg::word_t divisor,
  output logic               done,
  output rrc_pkg::word_t     quotient,
  output rrc_pkg::word_t     remainder
);

  logic                      running;
  logic [rrc_pkg::CNT_W-1:0] cnt;
  rrc_pkg::word_t            quo;
  rrc_pkg::word_t            rem;
  rrc_pkg::word_t            dvs;
  logic [rrc_pkg::DATA_WIDTH:0] trial;
  logic [rrc_pkg::DATA_WIDTH:0] diff;
  logic                      fits;

  assign trial = {rem, quo[rrc_pkg::DATA_WIDTH-1]};
  assign diff  = trial - {1'b0, dvs};
  assign fits  = !diff[rrc_pkg::DATA_WIDTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= rrc_pkg::CNT_W'(rrc_pkg::DATA_WIDTH);
      end else if (running) begin
        cnt <= cnt - rrc_pkg::CNT_W'(1);
        if (cnt == rrc_pkg::CNT_W'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  // Shift one dividend bit into the partial remainder per step.
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (running) begin
      quo <= {quo[rrc_pkg::DATA_WIDTH-2:0], fits};
      rem <= fits ? diff[rrc_pkg::DATA_WIDTH-1:0] : trial[rrc_pkg::DATA_WIDTH-1:0];
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule
`default_nettype wire

@@ rtl/rrc_reduce.sv @@
// Sequencer that reduces one fraction: Euclid remainder loop, then two
// divisions by the found divisor, all on one shared rrc_div. Depends on rrc_pkg.
`default_nettype none
module rrc_reduce (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  input  wire rrc_pkg::word_t num,
  input  wire rrc_pkg::word_t den,
  output logic                done,
  output logic                ok,
  output rrc_pkg::word_t      num_out,
  output rrc_pkg::word_t      den_out
);

  rrc_pkg::red_state_t state, state_next;

  logic           n_neg, d_neg, a_neg, b_neg;
  rrc_pkg::word_t n_mag, d_mag, a_mag, b_mag, qn;

  logic           div_start;
  rrc_pkg::word_t div_dvd, div_dvs;
  logic           div_done;
  rrc_pkg::word_t div_quo, div_rem;

  rrc_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dvd),
    .divisor   (div_dvs),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    div_dvd    = a_mag;
    div_dvs    = b_mag;
    case (state)
      rrc_pkg::R_IDLE: begin
        if (start) state_next = rrc_pkg::R_CHECK;
      end
      rrc_pkg::R_CHECK: begin
        if (b_mag != '0) begin
          div_start  = 1'b1;
          state_next = rrc_pkg::R_GCD;
        end else if (a_mag == '0) begin
          state_next = rrc_pkg::R_IDLE;
        end else begin
          div_start  = 1'b1;
          div_dvd    = n_mag;
          div_dvs    = a_mag;
          state_next = rrc_pkg::R_QN;
        end
      end
      rrc_pkg::R_GCD: begin
        if (div_done) state_next = rrc_pkg::R_CHECK;
      end
      rrc_pkg::R_QN: begin
        div_dvd = d_mag;
        div_dvs = a_mag;
        if (div_done) begin
          div_start  = 1'b1;
          state_next = rrc_pkg::R_QD;
        end
      end
      rrc_pkg::R_QD: begin
        if (div_done) state_next = rrc_pkg::R_IDLE;
      end
      default: state_next = rrc_pkg::R_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rrc_pkg::R_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= 1'b0;
      if (state == rrc_pkg::R_CHECK && b_mag == '0 && a_mag == '0) done <= 1'b1;
      if (state == rrc_pkg::R_QD && div_done) done <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      rrc_pkg::R_IDLE: begin
        if (start) begin
          n_neg <= num[rrc_pkg::DATA_WIDTH-1];
          n_mag <= rrc_pkg::abs_mag(num);
          d_neg <= den[rrc_pkg::DATA_WIDTH-1];
          d_mag <= rrc_pkg::abs_mag(den);
          a_neg <= num[rrc_pkg::DATA_WIDTH-1];
          a_mag <= rrc_pkg::abs_mag(num);
          b_neg <= den[rrc_pkg::DATA_WIDTH-1];
          b_mag <= rrc_pkg::abs_mag(den);
        end
      end
      rrc_pkg::R_CHECK: begin
        // 0/0: no divisor, report zeros
        if (b_mag == '0 && a_mag == '0) begin
          ok      <= 1'b0;
          num_out <= '0;
          den_out <= '0;
        end
      end
      rrc_pkg::R_GCD: begin
        // remainder keeps the dividend's sign (truncating rule)
        if (div_done) begin
          a_neg <= b_neg;
          a_mag <= b_mag;
          b_neg <= a_neg;
          b_mag <= div_rem;
        end
      end
      rrc_pkg::R_QN: begin
        if (div_done) qn <= div_quo;
      end
      rrc_pkg::R_QD: begin
        if (div_done) begin
          ok      <= 1'b1;
          num_out <= rrc_pkg::from_sm((n_neg != a_neg) && (qn != '0), qn);
          den_out <= rrc_pkg::from_sm((d_neg != a_neg) && (div_quo != '0), div_quo);
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire
